@@ hdl/mia_pkg.sv @@
package mia_pkg;

  localparam int MAX_DIM   = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int NUM_W     = ELEM_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(NUM_W);

  localparam logic signed [ELEM_W-1:0] ONE_FX  = ELEM_W'(1) << FRAC_BITS;
  localparam logic signed [ELEM_W-1:0] MAX_FX  = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] MIN_FX  = {1'b1, {(ELEM_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic CFG_DIM    = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  // Result of the iterative divider.
  typedef struct packed {
    logic             done;
    logic             neg;
    logic [NUM_W-1:0] mag;
  } div_res_t;

  function automatic logic signed [ELEM_W-1:0] sat32(logic signed [63:0] v);
    logic signed [ELEM_W-1:0] r;
    if (v > 64'(MAX_FX)) r = MAX_FX;
    else if (v < 64'(MIN_FX)) r = MIN_FX;
    else r = v[ELEM_W-1:0];
    return r;
  endfunction

  function automatic logic [2:0] eff_dim(logic [2:0] d);
    logic [2:0] r;
    if (d == 3'd0) r = 3'd1;
    else if (d > 3'(MAX_DIM)) r = 3'(MAX_DIM);
    else r = d;
    return r;
  endfunction

  function automatic logic [MAX_DIM-1:0] row_mask(logic [2:0] n);
    logic [MAX_DIM-1:0] m;
    for (int c = 0; c < MAX_DIM; c++) m[c] = (3'(c) < n);
    return m;
  endfunction

  // The k highest columns below n, leaving out column l.
  function automatic logic [MAX_DIM-1:0] col_set(logic [2:0] n, logic [2:0] l,
                                                 logic [2:0] k);
    logic [MAX_DIM-1:0] s;
    logic [2:0]         cnt;
    s   = '0;
    cnt = '0;
    for (int c = MAX_DIM - 1; c >= 0; c--) begin
      if (3'(c) < n && 3'(c) != l && cnt < k) begin
        s[c] = 1'b1;
        cnt  = cnt + 3'd1;
      end
    end
    return s;
  endfunction

  function automatic logic [1:0] low_col(logic [MAX_DIM-1:0] s);
    logic [1:0] idx;
    idx = '0;
    for (int c = MAX_DIM - 1; c >= 0; c--) begin
      if (s[c]) idx = 2'(c);
    end
    return idx;
  endfunction

  function automatic logic [2:0] pop4(logic [MAX_DIM-1:0] s);
    logic [2:0] p;
    p = '0;
    for (int c = 0; c < MAX_DIM; c++) p = p + 3'(s[c]);
    return p;
  endfunction

endpackage

@@ hdl/mia_div.sv @@
module mia_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mia_pkg::NUM_W-1:0]   num_i,
  input  logic signed [mia_pkg::ELEM_W-1:0]  den_i,
  output mia_pkg::div_res_t                  res_o
);
  import mia_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ELEM_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [ELEM_W-1:0] den_q, den_d;
  logic [ELEM_W:0]   trial;

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q[ELEM_W-1:0], quo_q[NUM_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      neg_d = num_i[NUM_W-1] ^ den_i[ELEM_W-1];
      quo_d = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_d = den_i[ELEM_W-1] ? ELEM_W'(-den_i) : ELEM_W'(den_i);
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign res_o.done = done_q;
  assign res_o.neg  = neg_q;
  assign res_o.mag  = quo_q;

endmodule

@@ hdl/matrix_inverse_by_adjugate.sv @@
// Matrix inverse by adjugate. Pulse start with one Q16.16 element while busy is low to load
// the matrix in row-major order, dim*dim beats in all (dim from the dim register, 0 taken as
// 1 and values above 4 as 4). Writing dim discards a partly loaded matrix. Loading takes one
// beat per cycle; the beat that brings the last element raises busy. The block then works out
// every minor it needs by cofactor expansion along the first column, one product term at a
// time through a single 32x32 multiplier, keeping the minors in a 256-entry scratch memory
// addressed by column set and row set. Then it emits dim*dim result beats in row-major
// order, each on out_valid_o for exactly one cycle, with the determinant and the singular
// flag on every beat and last on the final beat. Each non-singular element passes a
// bit-serial 48-bit divider, and singular elements skip it. The receiver cannot stall the
// results: they must be taken as they come. busy falls after the last beat.

module matrix_inverse_by_adjugate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mia_pkg::ELEM_W-1:0] element_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  output logic                              out_valid_o,
  output logic signed [mia_pkg::ELEM_W-1:0] inv_element_o,
  output logic signed [mia_pkg::ELEM_W-1:0] det_value_o,
  output logic                              singular_o,
  output logic                              last_o
);
  import mia_pkg::*;

  typedef enum logic [13:0] {
    S_LOAD = 14'b00000000000001,
    S_LIST = 14'b00000000000010,
    S_MASK = 14'b00000000000100,
    S_ADV  = 14'b00000000001000,
    S_TERM = 14'b00000000010000,
    S_MUL  = 14'b00000000100000,
    S_ACC  = 14'b00000001000000,
    S_WR   = 14'b00000010000000,
    S_CHK  = 14'b00000100000000,
    S_CHK2 = 14'b00001000000000,
    S_ORD  = 14'b00010000000000,
    S_OLAT = 14'b00100000000000,
    S_DIV  = 14'b01000000000000,
    S_STEP = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  dim_q, dim_d;
  logic [15:0] thr_q, thr_d;
  logic [1:0]  ld_r_q, ld_r_d, ld_c_q, ld_c_d;

  // Sweep over column lists, minor sizes and row sets.
  logic [2:0]  lst_q, lst_d;
  logic [2:0]  k_q, k_d;
  logic [3:0]  mask_q, mask_d;
  logic [1:0]  r_q, r_d;
  logic        par_q, par_d;
  logic        sub_empty_q, sub_empty_d;
  logic signed [34:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;

  logic [1:0]  i_q, i_d, j_q, j_d;
  logic signed [ELEM_W-1:0] det_q, det_d;
  logic        sing_q, sing_d;
  logic signed [ELEM_W-1:0] adj_q, adj_d;

  logic        ov_q, ov_d;
  logic signed [ELEM_W-1:0] inv_q, inv_d;
  logic        last_q, last_d;

  logic        div_go_q, div_go_d;
  logic        div_start;
  div_res_t    div_res;

  // Matrix store and minor scratch memory, both with registered reads.
  logic signed [ELEM_W-1:0] mat_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] det_mem [256];
  logic signed [ELEM_W-1:0] mat_rd_q, det_rd_q;
  logic        mat_we, det_we;
  logic [3:0]  mat_wa, mat_ra;
  logic [7:0]  det_wa, det_ra;
  logic signed [ELEM_W-1:0] det_wd;

  logic [2:0]  n;
  logic [3:0]  nmask;
  logic [2:0]  kmax;
  logic [3:0]  cs;
  logic [1:0]  lowc;
  logic [2:0]  n_less;
  logic signed [ELEM_W-1:0] term;
  logic signed [ELEM_W-1:0] adj_val;
  logic        accept;
  logic        ld_last;

  assign n       = eff_dim(dim_q);
  assign nmask   = row_mask(n);
  assign n_less  = n - 3'd1;
  assign kmax    = (lst_q == n) ? n : n_less;
  assign cs      = col_set(n, lst_q, k_q);
  assign lowc    = low_col(cs);
  assign term    = sat32(prod_q >>> FRAC_BITS);
  assign accept  = start && (state_q == S_LOAD);
  assign ld_last = ({1'b0, ld_r_q} == n_less) && ({1'b0, ld_c_q} == n_less);
  assign busy    = (state_q != S_LOAD);

  assign mat_we = accept;
  assign mat_wa = {ld_r_q, ld_c_q};
  assign mat_ra = {r_q, lowc};
  assign det_we = (state_q == S_WR);
  assign det_wa = {cs, mask_q};
  assign det_wd = sat32(64'(acc_q));

  always_comb begin
    case (state_q)
      S_CHK:   det_ra = {nmask, nmask};
      S_ORD:   det_ra = {col_set(n, {1'b0, i_q}, n_less), nmask & ~(4'b1 << j_q)};
      default: det_ra = {cs & ~(4'b1 << lowc), mask_q & ~(4'b1 << r_q)};
    endcase
  end

  // The adjugate term takes the cofactor sign; negating the most negative value saturates.
  always_comb begin
    adj_val = (n == 3'd1) ? ONE_FX : det_rd_q;
    if (i_q[0] ^ j_q[0]) begin
      adj_val = (adj_val == MIN_FX) ? MAX_FX : -adj_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[mat_wa] <= element_i;
    mat_rd_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (det_we) det_mem[det_wa] <= det_wd;
    det_rd_q <= det_mem[det_ra];
  end

  mia_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({adj_q, FRAC_BITS'(0)}),
    .den_i  (det_q),
    .res_o  (div_res)
  );

  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    thr_d       = thr_q;
    ld_r_d      = ld_r_q;
    ld_c_d      = ld_c_q;
    lst_d       = lst_q;
    k_d         = k_q;
    mask_d      = mask_q;
    r_d         = r_q;
    par_d       = par_q;
    sub_empty_d = sub_empty_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    i_d         = i_q;
    j_d         = j_q;
    det_d       = det_q;
    sing_d      = sing_q;
    adj_d       = adj_q;
    ov_d        = 1'b0;
    inv_d       = inv_q;
    last_d      = last_q;
    div_start   = div_go_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM: begin
          dim_d  = cfg_wdata_i[2:0];
          ld_r_d = '0;
          ld_c_d = '0;
        end
        CFG_THRESH: thr_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (ld_last) begin
            ld_r_d  = '0;
            ld_c_d  = '0;
            lst_d   = '0;
            state_d = S_LIST;
          end else if ({1'b0, ld_c_q} == n_less) begin
            ld_c_d = '0;
            ld_r_d = ld_r_q + 2'd1;
          end else begin
            ld_c_d = ld_c_q + 2'd1;
          end
        end
      end
      S_LIST: begin
        if (lst_q > n) begin
          state_d = S_CHK;
        end else if (kmax == 3'd0) begin
          lst_d = lst_q + 3'd1;
        end else begin
          k_d     = 3'd1;
          mask_d  = '0;
          state_d = S_MASK;
        end
      end
      S_MASK: begin
        if ((mask_q & ~nmask) == 4'd0 && pop4(mask_q) == k_q) begin
          acc_d   = '0;
          r_d     = '0;
          par_d   = 1'b0;
          state_d = S_TERM;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (mask_q == 4'hf) begin
          if (k_q == kmax) begin
            lst_d   = lst_q + 3'd1;
            state_d = S_LIST;
          end else begin
            k_d     = k_q + 3'd1;
            mask_d  = '0;
            state_d = S_MASK;
          end
        end else begin
          mask_d  = mask_q + 4'd1;
          state_d = S_MASK;
        end
      end
      S_TERM: begin
        if (mask_q[r_q]) begin
          sub_empty_d = ((mask_q & ~(4'b1 << r_q)) == 4'd0);
          state_d     = S_MUL;
        end else if (r_q == 2'd3) begin
          state_d = S_WR;
        end else begin
          r_d = r_q + 2'd1;
        end
      end
      S_MUL: begin
        prod_d  = 64'(mat_rd_q) * 64'(sub_empty_q ? ONE_FX : det_rd_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = par_q ? acc_q - 35'(term) : acc_q + 35'(term);
        par_d = ~par_q;
        if (r_q == 2'd3) begin
          state_d = S_WR;
        end else begin
          r_d     = r_q + 2'd1;
          state_d = S_TERM;
        end
      end
      S_WR: state_d = S_ADV;
      S_CHK: state_d = S_CHK2;
      S_CHK2: begin
        det_d   = det_rd_q;
        sing_d  = (det_rd_q == '0) ||
                  (((det_rd_q[ELEM_W-1]) ? -(ELEM_W+1)'(det_rd_q) : (ELEM_W+1)'(det_rd_q))
                   < (ELEM_W+1)'(thr_q));
        i_d     = '0;
        j_d     = '0;
        state_d = S_ORD;
      end
      S_ORD: state_d = S_OLAT;
      S_OLAT: begin
        adj_d  = adj_val;
        last_d = ({1'b0, i_q} == n_less) && ({1'b0, j_q} == n_less);
        if (sing_q) begin
          inv_d   = (i_q == j_q) ? ONE_FX : '0;
          ov_d    = 1'b1;
          state_d = S_STEP;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.neg) begin
            inv_d = (div_res.mag > NUM_W'(64'h8000_0000)) ? MIN_FX
                                                          : -ELEM_W'(div_res.mag);
          end else begin
            inv_d = (div_res.mag > NUM_W'(MAX_FX)) ? MAX_FX : ELEM_W'(div_res.mag);
          end
          ov_d    = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (last_q) begin
          state_d = S_LOAD;
        end else begin
          if ({1'b0, j_q} == n_less) begin
            j_d = '0;
            i_d = i_q + 2'd1;
          end else begin
            j_d = j_q + 2'd1;
          end
          state_d = S_ORD;
        end
      end
      default: state_d = S_LOAD;
    endcase

    // The divider starts on the cycle after the adjugate term is latched.
    div_go_d = (state_q == S_OLAT) && !sing_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      dim_q    <= 3'd4;
      thr_q    <= 16'd7;
      ld_r_q   <= '0;
      ld_c_q   <= '0;
      ov_q     <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dim_q    <= dim_d;
      thr_q    <= thr_d;
      ld_r_q   <= ld_r_d;
      ld_c_q   <= ld_c_d;
      ov_q     <= ov_d;
      div_go_q <= div_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lst_q       <= lst_d;
    k_q         <= k_d;
    mask_q      <= mask_d;
    r_q         <= r_d;
    par_q       <= par_d;
    sub_empty_q <= sub_empty_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    i_q         <= i_d;
    j_q         <= j_d;
    det_q       <= det_d;
    sing_q      <= sing_d;
    adj_q       <= adj_d;
    inv_q       <= inv_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign inv_element_o = inv_q;
  assign det_value_o   = det_q;
  assign singular_o    = sing_q;
  assign last_o        = last_q;

endmodule

@@ tb/mia_checker.sv @@
`timescale 1ns / 100ps

// Watches the load, configuration and result channels of the adjugate inverter,
// predicts every result beat and compares it field by field.
module mia_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic signed [mia_pkg::ELEM_W-1:0] element_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic                              out_valid_i,
  input  logic signed [mia_pkg::ELEM_W-1:0] inv_element_i,
  input  logic signed [mia_pkg::ELEM_W-1:0] det_value_i,
  input  logic                              singular_i,
  input  logic                              last_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import mia_pkg::*;

  typedef struct {
    logic signed [31:0] inv;
    logic signed [31:0] det;
    logic               sing;
    logic               last;
  } inv_beat_t;

  inv_beat_t          inverse_q[$];
  logic [2:0]         dim_reg;
  logic [15:0]        thresh_reg;
  logic signed [31:0] grid[MAX_DIM][MAX_DIM];
  int unsigned        loaded;

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Product rounded toward minus infinity: an arithmetic shift floors.
  function automatic logic signed [63:0] fx_product(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // Determinant of the rows and columns set in the masks, expanded along the
  // lowest column in the set.
  function automatic logic signed [63:0] minor_det(logic [3:0] rows, logic [3:0] cols);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    int                 c0;
    logic               odd;
    if (cols == 4'd0) return 64'sd65536;
    c0 = 0;
    for (int c = 3; c >= 0; c--) if (cols[c]) c0 = c;
    acc = 0;
    odd = 1'b0;
    for (int r = 0; r < 4; r++) begin
      if (rows[r]) begin
        term = fx_product(64'(grid[r][c0]),
                          minor_det(rows & ~(4'd1 << r), cols & ~(4'd1 << c0)));
        acc  = odd ? acc - term : acc + term;
        odd  = ~odd;
      end
    end
    return clamp32(acc);
  endfunction

  function automatic int unsigned dim_in_use();
    if (dim_reg == 3'd0) return 1;
    if (dim_reg > 3'(MAX_DIM)) return MAX_DIM;
    return dim_reg;
  endfunction

  task automatic predict_inverse(int unsigned n);
    logic [3:0]         all;
    logic signed [63:0] det;
    logic signed [63:0] mag;
    logic signed [63:0] adj;
    logic signed [63:0] v;
    logic               sing;
    inv_beat_t          b;
    all  = 4'((1 << n) - 1);
    det  = minor_det(all, all);
    mag  = det < 0 ? -det : det;
    sing = (det == 0) || (mag < 64'(thresh_reg));
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (sing) begin
          v = (i == j) ? 64'sd65536 : 64'sd0;
        end else begin
          // Adjugate (i,j) is the signed minor without row j and column i.
          adj = minor_det(all & ~(4'd1 << j), all & ~(4'd1 << i));
          if ((i + j) % 2 == 1) adj = clamp32(-adj);
          v = clamp32((adj * 64'sd65536) / det);
        end
        b.inv  = v[31:0];
        b.det  = det[31:0];
        b.sing = sing;
        b.last = (i == n - 1) && (j == n - 1);
        inverse_q.push_back(b);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    inv_beat_t   e;
    int unsigned n;
    if (!rst_ni) begin
      dim_reg    = 3'd4;
      thresh_reg = 16'd7;
      loaded     = 0;
      inverse_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DIM) begin
          dim_reg = cfg_wdata_i[2:0];
          loaded  = 0;
        end else begin
          thresh_reg = cfg_wdata_i;
        end
      end
      if (start_i && !busy_i) begin
        n = dim_in_use();
        if (loaded >= n * n) loaded = 0;
        grid[loaded / n][loaded % n] = element_i;
        loaded++;
        if (loaded == n * n) begin
          loaded = 0;
          predict_inverse(n);
        end
      end
      if (out_valid_i) begin
        if (inverse_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result beat inv=%0d", inv_element_i);
        end else begin
          e = inverse_q.pop_front();
          if (e.inv !== inv_element_i || e.det !== det_value_i ||
              e.sing !== singular_i || e.last !== last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: exp inv=%0d det=%0d sing=%0b last=%0b, got %0d %0d %0b %0b",
                       e.inv, e.det, e.sing, e.last,
                       inv_element_i, det_value_i, singular_i, last_i);
          end
        end
      end
    end
    pending_o = inverse_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Top of the bench: drives matrices into the inverter, rewrites the size and
// threshold registers between phases, and reports the verdict from the checker.
module tb_top;
  import mia_pkg::*;

  localparam int ITEM_GOAL  = 260;
  localparam int STALL_MAX  = 20000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] element_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               out_valid_o;
  logic signed [31:0] inv_element_o;
  logic signed [31:0] det_value_o;
  logic               singular_o;
  logic               last_o;
  int                 fail_count;
  int                 pending;

  // Bench bookkeeping.
  int unsigned items_sent = 0;
  int unsigned matrices_sent = 0;
  int unsigned size_now = 4;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  always #5 clk_i = ~clk_i;

  matrix_inverse_by_adjugate dut (
    .clk_i, .rst_ni, .start, .busy, .element_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .out_valid_o, .inv_element_o, .det_value_o, .singular_o, .last_o
  );

  mia_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .element_i, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .out_valid_i(out_valid_o), .inv_element_i(inv_element_o),
    .det_value_i(det_value_o), .singular_i(singular_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The watchdog restarts whenever a beat moves on either side. Hitting the
  // limit means the block has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("[matrix_inverse_by_adjugate] ERROR");
      $finish;
    end
  end

  // One element beat. start is only ever assigned once per falling edge, and
  // it is held high across back-to-back beats. busy changes at rising edges
  // only, so a low busy seen here means the beat is taken at the next edge.
  task automatic load_element(logic signed [31:0] v);
    @(negedge clk_i);
    while (busy || (!steady && $urandom_range(0, 99) < 19)) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    element_i <= v;
    items_sent++;
  endtask

  // Waits until every predicted beat has come out and the block has gone
  // quiet, then lets a few more cycles pass before a register write.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DIM) begin
      size_now = (value[2:0] == 0) ? 1 : (value[2:0] > MAX_DIM) ? MAX_DIM : value[2:0];
    end
  endtask

  // A random element: mostly modest values so that determinants stay in a
  // useful range, sometimes a raw word or an extreme.
  function automatic logic signed [31:0] pick_element();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    if (roll < 85) return $urandom;
    if (roll < 90) return 32'sh7FFF_FFFF;
    if (roll < 95) return 32'sh8000_0000;
    return 0;
  endfunction

  // A whole matrix; a repeated row now and then makes it singular.
  task automatic load_matrix();
    logic signed [31:0] m[MAX_DIM][MAX_DIM];
    bit                 twin;
    twin = (size_now > 1) && ($urandom_range(0, 5) == 0);
    for (int r = 0; r < size_now; r++)
      for (int c = 0; c < size_now; c++)
        m[r][c] = (twin && r == 1) ? m[0][c] : pick_element();
    for (int r = 0; r < size_now; r++)
      for (int c = 0; c < size_now; c++) load_element(m[r][c]);
    matrices_sent++;
  endtask

  initial begin
    int unsigned d;
    int unsigned thr_pick;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Dim zero is taken as one: single-element matrices give
    // the zero determinant, both extremes and a determinant under threshold.
    write_reg(CFG_DIM, 16'd0);
    load_element(0);
    load_element(32'sh7FFF_FFFF);
    load_element(32'sh8000_0000);
    load_element(1);
    load_element(ONE);
    // A zero threshold still calls a zero determinant singular.
    write_reg(CFG_THRESH, 16'd0);
    load_element(1);
    load_element(0);
    // Largest threshold: a determinant equal to it is not singular.
    write_reg(CFG_THRESH, 16'hFFFF);
    load_element(32'sh0000_FFFF);
    load_element(32'sh0000_FFFE);
    // Dim above the maximum is clamped; a partial load is then thrown away
    // by a dim write.
    write_reg(CFG_THRESH, 16'd7);
    write_reg(CFG_DIM, 16'hFFF7);
    load_element(ONE);
    load_element(-ONE);
    load_element(2 * ONE);
    write_reg(CFG_DIM, 16'd2);
    load_element(ONE);
    load_element(2 * ONE);
    load_element(3 * ONE);
    load_element(4 * ONE);
    matrices_sent += 10;

    // Random part: phases of one setting each, most of them small sizes.
    while (items_sent < ITEM_GOAL) begin
      steady = (items_sent >= 120 && items_sent < 180);
      d = $urandom_range(0, 9);
      d = (d < 3) ? 1 : (d < 6) ? 2 : (d < 9) ? 3 : 4;
      if (d == 1 && $urandom_range(0, 2) == 0) write_reg(CFG_DIM, 16'd0);
      else if (d == 4 && $urandom_range(0, 1) == 0) write_reg(CFG_DIM, 16'($urandom_range(5, 7)));
      else write_reg(CFG_DIM, 16'(d));
      thr_pick = $urandom_range(0, 3);
      write_reg(CFG_THRESH, thr_pick == 0 ? 16'd0 : thr_pick == 1 ? 16'hFFFF :
                            thr_pick == 2 ? 16'd7 : 16'($urandom));
      repeat ($urandom_range(1, d == 4 ? 2 : 6)) load_matrix();
      if (size_now > 1 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, size_now * size_now - 1)) load_element(pick_element());
        write_reg(CFG_DIM, 16'(size_now));
      end
    end

    settle();
    repeat (50) @(negedge clk_i);
    $display("Loaded %0d elements in about %0d matrices of sizes one to four,", items_sent,
             matrices_sent);
    $display("with zero, default, maximum and random singular thresholds.");
    if (fail_count == 0 && pending == 0) begin
      $display("[matrix_inverse_by_adjugate] OK");
    end else begin
      $display("[matrix_inverse_by_adjugate] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mia_pkg.sv
hdl/mia_div.sv
hdl/matrix_inverse_by_adjugate.sv
tb/mia_checker.sv
tb/tb_top.sv
